// ===== hdl/c8x_pkg.sv =====
`default_nettype none

package c8x_pkg;

    // Default geometry and sizes of the machine.
    localparam int SCREEN_WIDTH_DEF  = 64;
    localparam int SCREEN_HEIGHT_DEF = 32;
    localparam int STACK_DEPTH_DEF   = 16;
    localparam int MEMORY_BYTES_DEF  = 4096;

    localparam logic [11:0] PC_RESET = 12'h200;
    localparam logic [11:0] PC_STEP  = 12'd2;

    // Item modes.
    localparam logic [1:0] MODE_EXEC = 2'd0;
    localparam logic [1:0] MODE_LOAD = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    // Major opcode nibbles.
    localparam logic [3:0] OP_SYS  = 4'h0;
    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;
    localparam logic [3:0] OP_SE   = 4'h3;
    localparam logic [3:0] OP_SNE  = 4'h4;
    localparam logic [3:0] OP_SER  = 4'h5;
    localparam logic [3:0] OP_LD   = 4'h6;
    localparam logic [3:0] OP_ADD  = 4'h7;
    localparam logic [3:0] OP_ALU  = 4'h8;
    localparam logic [3:0] OP_SNER = 4'h9;
    localparam logic [3:0] OP_LDI  = 4'hA;
    localparam logic [3:0] OP_JPV0 = 4'hB;
    localparam logic [3:0] OP_RND  = 4'hC;
    localparam logic [3:0] OP_DRW  = 4'hD;
    localparam logic [3:0] OP_KEY  = 4'hE;
    localparam logic [3:0] OP_MISC = 4'hF;

    // Whole words of the system group.
    localparam logic [15:0] OP_CLS = 16'h00E0;
    localparam logic [15:0] OP_RET = 16'h00EE;

    // Register to register operations.
    localparam logic [3:0] F8_LD   = 4'h0;
    localparam logic [3:0] F8_OR   = 4'h1;
    localparam logic [3:0] F8_AND  = 4'h2;
    localparam logic [3:0] F8_XOR  = 4'h3;
    localparam logic [3:0] F8_ADD  = 4'h4;
    localparam logic [3:0] F8_SUB  = 4'h5;
    localparam logic [3:0] F8_SHR  = 4'h6;
    localparam logic [3:0] F8_SUBN = 4'h7;
    localparam logic [3:0] F8_SHL  = 4'hE;

    // Low byte codes of the key and miscellaneous groups.
    localparam logic [7:0] KK_SKP   = 8'h9E;
    localparam logic [7:0] KK_SKNP  = 8'hA1;
    localparam logic [7:0] KK_LDDT  = 8'h07;
    localparam logic [7:0] KK_WAITK = 8'h0A;
    localparam logic [7:0] KK_SETDT = 8'h15;
    localparam logic [7:0] KK_SETST = 8'h18;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_OVER    = 2'd2,
        ST_UNDER   = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        t_alu_op     op;
        logic [11:0] a;
        logic [11:0] b;
    } t_alu_req;

endpackage

`default_nettype wire

// ===== hdl/c8x_in_if.sv =====
`default_nettype none

interface c8x_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] opcode;
    logic [15:0] keys;
    logic [7:0]  random_byte;
    logic [11:0] load_address;
    logic [7:0]  load_data;
    logic [4:0]  row_select;

    modport source (output valid, mode, opcode, keys, random_byte, load_address,
                    load_data, row_select, input ready);
    modport sink (input valid, mode, opcode, keys, random_byte, load_address,
                  load_data, row_select, output ready);
endinterface

`default_nettype wire

// ===== hdl/c8x_out_if.sv =====
`default_nettype none

interface c8x_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] next_pc;
    logic [11:0] index_value;
    logic [7:0]  flag_value;
    logic [63:0] display_row;
    logic [7:0]  delay_value;
    logic [7:0]  sound_value;
    logic        waiting_key;
    logic        screen_changed;
    logic [1:0]  status;

    modport source (output valid, next_pc, index_value, flag_value, display_row,
                    delay_value, sound_value, waiting_key, screen_changed, status,
                    input ready);
    modport sink (input valid, next_pc, index_value, flag_value, display_row,
                  delay_value, sound_value, waiting_key, screen_changed, status,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/c8x_ram.sv =====
`default_nettype none

module c8x_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/c8x_alu.sv =====
`default_nettype none

module c8x_alu
    import c8x_pkg::*;
(
    input  wire t_alu_req    i_req,
    output logic [12:0]      o_res
);

    // Shared 12-bit adder and subtractor; bit 12 carries the carry or borrow.
    always_comb begin
        unique case (i_req.op)
            ALU_SUB: o_res = {1'b0, i_req.a} - {1'b0, i_req.b};
            default: o_res = {1'b0, i_req.a} + {1'b0, i_req.b};
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/chip8_instruction_execute.sv =====
`default_nettype none

// CHIP-8 execute unit. Each input transaction either executes one instruction
// (mode 0), writes one program memory byte (mode 1), reads one frame buffer
// row (mode 2) or changes nothing (mode 3), and yields exactly one result
// transaction holding the state after it. A small sequencer drives one shared
// 12-bit adder, so an item is worked through in steps and the input is not
// ready meanwhile: a clear blanks the frame buffer row by row, and a draw
// reduces the wrap of the start position by repeated subtraction, then walks
// the sprite rows, each sprite byte costing one registered read of program
// memory. A result that is not yet taken stays in the output register while
// the next transaction is accepted.
module chip8_instruction_execute
    import c8x_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
    parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
    parameter int MEMORY_BYTES  = MEMORY_BYTES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    c8x_in_if.sink     i_in,
    c8x_out_if.source  o_out
);

    localparam int FBW = $clog2(SCREEN_HEIGHT);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int MAW = $clog2(MEMORY_BYTES);
    localparam logic [63:0] COL_MASK = ~({64{1'b1}} >> SCREEN_WIDTH);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_ADV   = 13'b0000000000010,
        S_RDY   = 13'b0000000000100,
        S_EXEC  = 13'b0000000001000,
        S_SKIP  = 13'b0000000010000,
        S_BACK  = 13'b0000000100000,
        S_RET   = 13'b0000001000000,
        S_CLR   = 13'b0000010000000,
        S_MODX  = 13'b0000100000000,
        S_MODY  = 13'b0001000000000,
        S_DADDR = 13'b0010000000000,
        S_DDATA = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } t_state;

    t_state      r_state;
    logic [11:0] r_pc;
    logic [11:0] r_i;
    logic [SPW-1:0] r_sp;
    logic [7:0]  r_dt;
    logic [7:0]  r_st;
    logic [7:0]  r_gr [16];
    logic [63:0] r_fb [SCREEN_HEIGHT];

    // Latched item and working values.
    logic [15:0] r_op;
    logic [15:0] r_keys;
    logic [7:0]  r_rnd;
    logic [7:0]  r_vx;
    logic [7:0]  r_vy;
    logic [7:0]  r_xs;
    logic [7:0]  r_ys;
    logic [7:0]  r_py;
    logic [4:0]  r_row;
    logic        r_hit;
    logic        r_oob;
    logic        r_wait;
    logic        r_chg;
    t_status     r_status;
    logic [63:0] r_disp;

    // Output register.
    logic        r_ov;
    logic [11:0] r_o_pc;
    logic [11:0] r_o_i;
    logic [7:0]  r_o_vf;
    logic [63:0] r_o_disp;
    logic [7:0]  r_o_dt;
    logic [7:0]  r_o_st;
    logic        r_o_wait;
    logic        r_o_chg;
    t_status     r_o_status;

    logic [3:0]  op_hi;
    logic [3:0]  op_x;
    logic [3:0]  op_y;
    logic [3:0]  op_n;
    logic [7:0]  op_kk;
    logic [11:0] op_nnn;
    logic [3:0]  gr_ra;
    logic [7:0]  gr_rd;
    logic [6:0]  row_ext;
    logic [FBW-1:0] fb_idx;
    logic [63:0] fb_rd;
    logic [63:0] spr_mask;
    logic [7:0]  sprite;
    logic        key_bit;
    logic        key_found;
    logic [3:0]  key_idx;
    logic [SPW-1:0] sp_m1;
    logic        out_free;
    t_alu_req    alu_req;
    logic [12:0] alu_res;
    logic        stk_we;
    logic [11:0] stk_rdata;
    logic        mem_we;
    logic [7:0]  mem_rdata;

    assign op_hi  = r_op[15:12];
    assign op_x   = r_op[11:8];
    assign op_y   = r_op[7:4];
    assign op_n   = r_op[3:0];
    assign op_kk  = r_op[7:0];
    assign op_nnn = r_op[11:0];
    assign sp_m1  = r_sp - 1'b1;
    assign out_free = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // Single read port of the general registers.
    assign gr_ra = (r_state == S_ADV) ? op_x : ((op_hi == OP_JPV0) ? 4'h0 : op_y);
    assign gr_rd = r_gr[gr_ra];

    // Single read port of the frame buffer.
    assign row_ext = {2'b00, i_in.row_select};
    assign fb_idx  = (r_state == S_IDLE) ? row_ext[FBW-1:0] : r_py[FBW-1:0];
    assign fb_rd   = r_fb[fb_idx];

    // Sprite byte placed at its column and clipped at the right edge.
    assign sprite   = r_oob ? 8'h00 : mem_rdata;
    assign spr_mask = ({sprite, 56'h0} >> r_xs[5:0]) & COL_MASK;

    assign key_bit = r_keys[r_vx[3:0]];

    // Lowest numbered pressed key.
    always_comb begin
        key_found = 1'b0;
        key_idx   = 4'h0;
        for (int k = 15; k >= 0; k--) begin
            if (r_keys[k]) begin
                key_found = 1'b1;
                key_idx   = 4'(k);
            end
        end
    end

    // Operand selection for the shared adder.
    always_comb begin
        alu_req = '{op: ALU_ADD, a: r_pc, b: PC_STEP};
        unique case (r_state)
            S_BACK: alu_req.op = ALU_SUB;
            S_EXEC: begin
                case (op_hi)
                    OP_ADD: alu_req = '{op: ALU_ADD, a: {4'h0, r_vx}, b: {4'h0, op_kk}};
                    OP_ALU: begin
                        if (op_n == F8_SUBN) begin
                            alu_req = '{op: ALU_SUB, a: {4'h0, r_vy}, b: {4'h0, r_vx}};
                        end else if (op_n == F8_SUB) begin
                            alu_req = '{op: ALU_SUB, a: {4'h0, r_vx}, b: {4'h0, r_vy}};
                        end else begin
                            alu_req = '{op: ALU_ADD, a: {4'h0, r_vx}, b: {4'h0, r_vy}};
                        end
                    end
                    OP_JPV0: alu_req = '{op: ALU_ADD, a: op_nnn, b: {4'h0, r_vy}};
                    default: ;
                endcase
            end
            S_MODX:  alu_req = '{op: ALU_SUB, a: {4'h0, r_xs}, b: 12'(SCREEN_WIDTH)};
            S_MODY:  alu_req = '{op: ALU_SUB, a: {4'h0, r_ys}, b: 12'(SCREEN_HEIGHT)};
            S_DADDR: alu_req = '{op: ALU_ADD, a: r_i, b: {7'h0, r_row}};
            default: ;
        endcase
    end

    c8x_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    // Return stack: pushed at the call, read in the cycle before the return.
    assign stk_we = (r_state == S_EXEC) && (op_hi == OP_CALL)
                    && (r_sp < SPW'(STACK_DEPTH));

    c8x_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_sp[SAW-1:0]),
        .i_wdata (r_pc),
        .i_raddr (sp_m1[SAW-1:0]),
        .o_rdata (stk_rdata)
    );

    // Program memory: loaded in mode 1, read by the sprite walk.
    assign mem_we = (r_state == S_IDLE) && i_in.valid && (i_in.mode == MODE_LOAD)
                    && ({1'b0, i_in.load_address} < 13'(MEMORY_BYTES));

    c8x_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (i_in.load_address[MAW-1:0]),
        .i_wdata (i_in.load_data),
        .i_raddr (alu_res[MAW-1:0]),
        .o_rdata (mem_rdata)
    );

    // Sequencer and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= PC_RESET;
            r_i     <= '0;
            r_sp    <= '0;
            r_dt    <= '0;
            r_st    <= '0;
            r_ov    <= 1'b0;
            for (int k = 0; k < 16; k++) begin
                r_gr[k] <= '0;
            end
            for (int k = 0; k < SCREEN_HEIGHT; k++) begin
                r_fb[k] <= '0;
            end
        end else begin
            // A finished result moves to the output register once it is free.
            if ((r_state == S_DONE) && out_free) begin
                r_ov       <= 1'b1;
                r_o_pc     <= r_pc;
                r_o_i      <= r_i;
                r_o_vf     <= r_gr[15];
                r_o_disp   <= r_disp;
                r_o_dt     <= r_dt;
                r_o_st     <= r_st;
                r_o_wait   <= r_wait;
                r_o_chg    <= r_chg;
                r_o_status <= r_status;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_op     <= i_in.opcode;
                        r_keys   <= i_in.keys;
                        r_rnd    <= i_in.random_byte;
                        r_status <= ST_OK;
                        r_wait   <= 1'b0;
                        r_chg    <= 1'b0;
                        r_disp   <= '0;
                        r_state  <= S_DONE;
                        if (i_in.mode == MODE_EXEC) begin
                            r_state <= S_ADV;
                        end else if (i_in.mode == MODE_READ) begin
                            if (row_ext < 7'(SCREEN_HEIGHT)) begin
                                r_disp <= fb_rd;
                            end
                        end
                    end
                end
                S_ADV: begin
                    r_pc    <= alu_res[11:0];
                    r_vx    <= gr_rd;
                    r_state <= S_RDY;
                end
                S_RDY: begin
                    r_vy    <= gr_rd;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_state <= S_DONE;
                    case (op_hi)
                        OP_SYS: begin
                            if (r_op == OP_CLS) begin
                                r_py    <= '0;
                                r_state <= S_CLR;
                            end else if (r_op == OP_RET) begin
                                if (r_sp == '0) begin
                                    r_status <= ST_UNDER;
                                end else begin
                                    r_sp    <= sp_m1;
                                    r_state <= S_RET;
                                end
                            end else begin
                                r_status <= ST_UNKNOWN;
                            end
                        end
                        OP_JP: r_pc <= op_nnn;
                        OP_CALL: begin
                            if (r_sp >= SPW'(STACK_DEPTH)) begin
                                r_status <= ST_OVER;
                            end else begin
                                r_sp <= r_sp + 1'b1;
                                r_pc <= op_nnn;
                            end
                        end
                        OP_SE: begin
                            if (r_vx == op_kk) r_state <= S_SKIP;
                        end
                        OP_SNE: begin
                            if (r_vx != op_kk) r_state <= S_SKIP;
                        end
                        OP_SER, OP_SNER: begin
                            if (op_n != 4'h0) begin
                                r_status <= ST_UNKNOWN;
                            end else if ((r_vx == r_vy) == (op_hi == OP_SER)) begin
                                r_state <= S_SKIP;
                            end
                        end
                        OP_LD:  r_gr[op_x] <= op_kk;
                        OP_ADD: r_gr[op_x] <= alu_res[7:0];
                        OP_ALU: begin
                            case (op_n)
                                F8_LD:  r_gr[op_x] <= r_vy;
                                F8_OR:  r_gr[op_x] <= r_vx | r_vy;
                                F8_AND: r_gr[op_x] <= r_vx & r_vy;
                                F8_XOR: r_gr[op_x] <= r_vx ^ r_vy;
                                F8_ADD: begin
                                    r_gr[15]   <= {7'h0, alu_res[8]};
                                    r_gr[op_x] <= alu_res[7:0];
                                end
                                F8_SUB, F8_SUBN: begin
                                    r_gr[15]   <= {7'h0, !alu_res[12]};
                                    r_gr[op_x] <= alu_res[7:0];
                                end
                                F8_SHR: begin
                                    r_gr[15]   <= {7'h0, r_vx[0]};
                                    r_gr[op_x] <= {1'b0, r_vx[7:1]};
                                end
                                F8_SHL: begin
                                    r_gr[15]   <= {7'h0, r_vx[7]};
                                    r_gr[op_x] <= {r_vx[6:0], 1'b0};
                                end
                                default: r_status <= ST_UNKNOWN;
                            endcase
                        end
                        OP_LDI:  r_i <= op_nnn;
                        OP_JPV0: r_pc <= alu_res[11:0];
                        OP_RND:  r_gr[op_x] <= r_rnd & op_kk;
                        OP_DRW: begin
                            r_xs    <= r_vx;
                            r_ys    <= r_vy;
                            r_row   <= '0;
                            r_hit   <= 1'b0;
                            r_state <= S_MODX;
                        end
                        OP_KEY: begin
                            if (op_kk == KK_SKP) begin
                                if (key_bit) r_state <= S_SKIP;
                            end else if (op_kk == KK_SKNP) begin
                                if (!key_bit) r_state <= S_SKIP;
                            end else begin
                                r_status <= ST_UNKNOWN;
                            end
                        end
                        default: begin
                            case (op_kk)
                                KK_LDDT: r_gr[op_x] <= r_dt;
                                KK_WAITK: begin
                                    if (key_found) begin
                                        r_gr[op_x] <= {4'h0, key_idx};
                                    end else begin
                                        r_wait  <= 1'b1;
                                        r_state <= S_BACK;
                                    end
                                end
                                KK_SETDT: r_dt <= r_vx;
                                KK_SETST: r_st <= r_vx;
                                default:  r_status <= ST_UNKNOWN;
                            endcase
                        end
                    endcase
                end
                S_SKIP, S_BACK: begin
                    r_pc    <= alu_res[11:0];
                    r_state <= S_DONE;
                end
                S_RET: begin
                    r_pc    <= stk_rdata;
                    r_state <= S_DONE;
                end
                S_CLR: begin
                    // One row a cycle: note any lit pixel, then blank the row.
                    r_chg        <= r_chg | (|fb_rd);
                    r_fb[fb_idx] <= '0;
                    if (r_py == 8'(SCREEN_HEIGHT - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_py <= r_py + 1'b1;
                    end
                end
                S_MODX: begin
                    if (!alu_res[12]) begin
                        r_xs <= alu_res[7:0];
                    end else begin
                        r_state <= S_MODY;
                    end
                end
                S_MODY: begin
                    if (!alu_res[12]) begin
                        r_ys <= alu_res[7:0];
                    end else begin
                        r_py    <= r_ys;
                        r_state <= S_DADDR;
                    end
                end
                S_DADDR: begin
                    // Stop after the last sprite row or at the bottom edge.
                    if ((r_row == {1'b0, op_n}) || (r_py >= 8'(SCREEN_HEIGHT))) begin
                        r_gr[15] <= {7'h0, r_hit};
                        r_state  <= S_DONE;
                    end else begin
                        r_oob   <= ({1'b0, alu_res[11:0]} >= 13'(MEMORY_BYTES));
                        r_state <= S_DDATA;
                    end
                end
                S_DDATA: begin
                    r_fb[fb_idx] <= fb_rd ^ spr_mask;
                    r_hit        <= r_hit | (|(fb_rd & spr_mask));
                    r_chg        <= r_chg | (|spr_mask);
                    r_row        <= r_row + 1'b1;
                    r_py         <= r_py + 1'b1;
                    r_state      <= S_DADDR;
                end
                S_DONE: begin
                    if (out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid          = r_ov;
    assign o_out.next_pc        = r_o_pc;
    assign o_out.index_value    = r_o_i;
    assign o_out.flag_value     = r_o_vf;
    assign o_out.display_row    = r_o_disp;
    assign o_out.delay_value    = r_o_dt;
    assign o_out.sound_value    = r_o_st;
    assign o_out.waiting_key    = r_o_wait;
    assign o_out.screen_changed = r_o_chg;
    assign o_out.status         = r_o_status;

    // The stack pointer never passes the stack depth.
    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    // An executed instruction starts with the program counter advance.
    a_exec_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.mode == MODE_EXEC) |=> (r_state == S_ADV))
        else $error("execute item did not start with the pc advance");

    // A key wait or a screen change only comes from a recognised instruction.
    a_flag_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && (r_o_wait || r_o_chg)) |-> (r_o_status == ST_OK))
        else $error("waiting or changed result with a non-ok status");

endmodule

`default_nettype wire

// ===== tb/tb_chip8_instruction_execute.sv =====
`default_nettype none

module tb_chip8_instruction_execute;
    import c8x_pkg::*;

    localparam int RANDOM_ITEMS = 1900;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        logic [1:0]  mode;
        logic [15:0] opcode;
        logic [15:0] keys;
        logic [7:0]  random_byte;
        logic [11:0] load_address;
        logic [7:0]  load_data;
        logic [4:0]  row_select;
    } t_item;

    typedef struct {
        logic [11:0] next_pc;
        logic [11:0] index_value;
        logic [7:0]  flag_value;
        logic [63:0] display_row;
        logic [7:0]  delay_value;
        logic [7:0]  sound_value;
        logic        waiting_key;
        logic        screen_changed;
        t_status     status;
    } t_result;

    // A directed row; where known is set the result is given by pc and status,
    // every other field being at its reset value.
    typedef struct {
        t_item       it;
        logic        known;
        logic [11:0] pc;
        t_status     status;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    c8x_in_if  in_bus ();
    c8x_out_if out_bus ();

    chip8_instruction_execute u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // Machine state as the block should hold it.
    logic [7:0]  v_reg [16];
    logic [11:0] pc_q;
    logic [11:0] idx_q;
    int unsigned sp_q;
    logic [11:0] call_stack [STACK_DEPTH_DEF];
    logic [7:0]  delay_q;
    logic [7:0]  sound_q;
    logic [7:0]  mem_q [MEMORY_BYTES_DEF];
    bit          mem_written [MEMORY_BYTES_DEF];
    logic [63:0] screen_q [SCREEN_HEIGHT_DEF];

    t_result expected_q [$];
    int      error_count = 0;
    int      tx_idle_pct = 0;
    int      rx_stall_pct = 0;
    logic [15:0] call_burst_q [$];

    // Clock.
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Overall limit on the run.
    initial begin
        #20000000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [11:0] add_pc(logic [11:0] a, logic [11:0] b);
        return a + b;
    endfunction

    // Apply one transaction to the machine state and return the result it yields.
    function automatic t_result apply_item(t_item it);
        t_result     r;
        logic [15:0] op;
        logic [3:0]  x, y, n;
        logic [7:0]  kk, vx, vy, sprite;
        logic [11:0] nnn;
        int          xs, ys, py, px;
        bit          hit;
        op  = it.opcode;
        x   = op[11:8];
        y   = op[7:4];
        n   = op[3:0];
        kk  = op[7:0];
        nnn = op[11:0];
        vx  = v_reg[x];
        vy  = v_reg[y];
        r.display_row = '0;
        r.waiting_key = 1'b0;
        r.screen_changed = 1'b0;
        r.status = ST_OK;
        if (it.mode == MODE_EXEC) begin
            pc_q = add_pc(pc_q, PC_STEP);
            case (op[15:12])
                OP_SYS: begin
                    if (op == OP_CLS) begin
                        foreach (screen_q[k]) begin
                            if (screen_q[k] != '0) r.screen_changed = 1'b1;
                            screen_q[k] = '0;
                        end
                    end else if (op == OP_RET) begin
                        if (sp_q == 0) begin
                            r.status = ST_UNDER;
                        end else begin
                            sp_q--;
                            pc_q = call_stack[sp_q];
                        end
                    end else begin
                        r.status = ST_UNKNOWN;
                    end
                end
                OP_JP: pc_q = nnn;
                OP_CALL: begin
                    if (sp_q >= STACK_DEPTH_DEF) begin
                        r.status = ST_OVER;
                    end else begin
                        call_stack[sp_q] = pc_q;
                        sp_q++;
                        pc_q = nnn;
                    end
                end
                OP_SE:  if (vx == kk) pc_q = add_pc(pc_q, PC_STEP);
                OP_SNE: if (vx != kk) pc_q = add_pc(pc_q, PC_STEP);
                OP_SER: begin
                    if (n != 0) r.status = ST_UNKNOWN;
                    else if (vx == vy) pc_q = add_pc(pc_q, PC_STEP);
                end
                OP_LD:  v_reg[x] = kk;
                OP_ADD: v_reg[x] = vx + kk;
                OP_ALU: begin
                    // The flag goes in first, so Vx wins when x names VF.
                    case (n)
                        F8_LD:  v_reg[x] = vy;
                        F8_OR:  v_reg[x] = vx | vy;
                        F8_AND: v_reg[x] = vx & vy;
                        F8_XOR: v_reg[x] = vx ^ vy;
                        F8_ADD: begin
                            v_reg[15] = ({1'b0, vx} + {1'b0, vy} > 9'hFF) ? 8'd1 : 8'd0;
                            v_reg[x] = vx + vy;
                        end
                        F8_SUB: begin
                            v_reg[15] = (vx >= vy) ? 8'd1 : 8'd0;
                            v_reg[x] = vx - vy;
                        end
                        F8_SHR: begin
                            v_reg[15] = {7'd0, vx[0]};
                            v_reg[x] = vx >> 1;
                        end
                        F8_SUBN: begin
                            v_reg[15] = (vy >= vx) ? 8'd1 : 8'd0;
                            v_reg[x] = vy - vx;
                        end
                        F8_SHL: begin
                            v_reg[15] = {7'd0, vx[7]};
                            v_reg[x] = vx << 1;
                        end
                        default: r.status = ST_UNKNOWN;
                    endcase
                end
                OP_SNER: begin
                    if (n != 0) r.status = ST_UNKNOWN;
                    else if (vx != vy) pc_q = add_pc(pc_q, PC_STEP);
                end
                OP_LDI:  idx_q = nnn;
                OP_JPV0: pc_q = add_pc(nnn, {4'd0, v_reg[0]});
                OP_RND:  v_reg[x] = it.random_byte & kk;
                OP_DRW: begin
                    // Sprite rows past the bottom and columns past the right are clipped.
                    xs = vx % SCREEN_WIDTH_DEF;
                    ys = vy % SCREEN_HEIGHT_DEF;
                    hit = 1'b0;
                    for (int row = 0; row < n; row++) begin
                        py = ys + row;
                        sprite = mem_q[add_pc(idx_q, 12'(row))];
                        if (py >= SCREEN_HEIGHT_DEF) break;
                        for (int col = 0; col < 8; col++) begin
                            px = xs + col;
                            if (px >= SCREEN_WIDTH_DEF) break;
                            if (sprite[7 - col]) begin
                                if (screen_q[py][63 - px]) hit = 1'b1;
                                screen_q[py][63 - px] = ~screen_q[py][63 - px];
                                r.screen_changed = 1'b1;
                            end
                        end
                    end
                    v_reg[15] = {7'd0, hit};
                end
                OP_KEY: begin
                    if (kk == KK_SKP) begin
                        if (it.keys[vx[3:0]]) pc_q = add_pc(pc_q, PC_STEP);
                    end else if (kk == KK_SKNP) begin
                        if (!it.keys[vx[3:0]]) pc_q = add_pc(pc_q, PC_STEP);
                    end else begin
                        r.status = ST_UNKNOWN;
                    end
                end
                default: begin
                    case (kk)
                        KK_LDDT: v_reg[x] = delay_q;
                        KK_WAITK: begin
                            // Lowest pressed key wins; with none the pc steps back.
                            if (it.keys == '0) begin
                                pc_q = pc_q - PC_STEP;
                                r.waiting_key = 1'b1;
                            end else begin
                                for (int k = 15; k >= 0; k--)
                                    if (it.keys[k]) v_reg[x] = 8'(k);
                            end
                        end
                        KK_SETDT: delay_q = vx;
                        KK_SETST: sound_q = vx;
                        default:  r.status = ST_UNKNOWN;
                    endcase
                end
            endcase
        end else if (it.mode == MODE_LOAD) begin
            mem_q[it.load_address] = it.load_data;
            mem_written[it.load_address] = 1'b1;
        end else if (it.mode == MODE_READ) begin
            r.display_row = screen_q[it.row_select];
        end
        r.next_pc = pc_q;
        r.index_value = idx_q;
        r.flag_value = v_reg[15];
        r.delay_value = delay_q;
        r.sound_value = sound_q;
        return r;
    endfunction

    // A draw only reads sprite bytes that have been written: the height is cut back.
    function automatic t_item trim_draw(t_item it);
        int rows;
        if (it.mode == MODE_EXEC && it.opcode[15:12] == OP_DRW) begin
            rows = 0;
            while (rows < it.opcode[3:0] && mem_written[add_pc(idx_q, 12'(rows))])
                rows++;
            it.opcode[3:0] = 4'(rows);
        end
        return it;
    endfunction

    function automatic t_item random_item();
        t_item it;
        int    pick;
        it.mode = MODE_EXEC;
        it.opcode = 16'($urandom);
        it.keys = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
        it.random_byte = 8'($urandom);
        it.load_address = 12'($urandom);
        it.load_data = 8'($urandom);
        it.row_select = 5'($urandom);
        pick = $urandom_range(0, 99);
        if (call_burst_q.size() != 0) begin
            it.opcode = call_burst_q.pop_front();
        end else if (pick < 12) begin
            it.mode = MODE_LOAD;
            // Half the time, fill the bytes that the next draw will read.
            if ($urandom_range(0, 1) == 0)
                it.load_address = add_pc(idx_q, 12'($urandom_range(0, 15)));
        end else if (pick < 22) begin
            it.mode = MODE_READ;
        end else if (pick < 24) begin
            it.mode = 2'd3;
        end else if (pick < 26) begin
            // A run of calls past the stack depth, then returns past the bottom.
            repeat (STACK_DEPTH_DEF + 2) call_burst_q.push_back({OP_CALL, 12'($urandom)});
            repeat (STACK_DEPTH_DEF + 3) call_burst_q.push_back(OP_RET);
            it.opcode = call_burst_q.pop_front();
        end else if (pick < 34) begin
            // Raw words, unknown forms among them.
        end else begin
            case (it.opcode[15:12])
                OP_SYS: begin
                    pick = $urandom_range(0, 9);
                    if (pick < 3) it.opcode = OP_CLS;
                    else if (pick < 8) it.opcode = OP_RET;
                end
                OP_SER, OP_SNER: it.opcode[3:0] = 4'd0;
                OP_ALU: begin
                    pick = $urandom_range(0, 8);
                    it.opcode[3:0] = (pick == 8) ? F8_SHL : 4'(pick);
                end
                OP_SE, OP_SNE: if ($urandom_range(0, 1) == 0) it.opcode[7:0] = v_reg[it.opcode[11:8]];
                OP_KEY: it.opcode[7:0] = ($urandom_range(0, 1) == 0) ? KK_SKP : KK_SKNP;
                OP_MISC: begin
                    case ($urandom_range(0, 3))
                        0: it.opcode[7:0] = KK_LDDT;
                        1: it.opcode[7:0] = KK_WAITK;
                        2: it.opcode[7:0] = KK_SETDT;
                        default: it.opcode[7:0] = KK_SETST;
                    endcase
                end
                default: ;
            endcase
        end
        return it;
    endfunction

    // Send one transaction, record its expected result and idle afterwards at random.
    task automatic send_item(t_item it, logic known, logic [11:0] pc, t_status st);
        t_result r;
        in_bus.valid        <= 1'b1;
        in_bus.mode         <= it.mode;
        in_bus.opcode       <= it.opcode;
        in_bus.keys         <= it.keys;
        in_bus.random_byte  <= it.random_byte;
        in_bus.load_address <= it.load_address;
        in_bus.load_data    <= it.load_data;
        in_bus.row_select   <= it.row_select;
        do @(posedge i_clk); while (!in_bus.ready);
        r = apply_item(it);
        if (known) begin
            r = '{pc, 12'd0, 8'd0, 64'd0, 8'd0, 8'd0, 1'b0, 1'b0, st};
        end
        expected_q.push_back(r);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            in_bus.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
    endtask

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Result side: check each transaction and stall at random.
    initial out_bus.ready = 1'b0;
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: result transaction with no expectation waiting", $time);
                error_count++;
            end else begin
                e = expected_q.pop_front();
                check_field("next_pc", e.next_pc, out_bus.next_pc);
                check_field("index_value", e.index_value, out_bus.index_value);
                check_field("flag_value", e.flag_value, out_bus.flag_value);
                check_field("display_row", e.display_row, out_bus.display_row);
                check_field("delay_value", e.delay_value, out_bus.delay_value);
                check_field("sound_value", e.sound_value, out_bus.sound_value);
                check_field("waiting_key", e.waiting_key, out_bus.waiting_key);
                check_field("screen_changed", e.screen_changed, out_bus.screen_changed);
                check_field("status", e.status, out_bus.status);
            end
        end
        out_bus.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Directed rows, the first few straight after reset with known results.
    t_row directed [] = '{
        '{'{MODE_READ, 16'h0000, 16'h0000, 8'h00, 12'h000, 8'h00, 5'd0}, 1'b1, 12'h200, ST_OK},
        '{'{MODE_READ, 16'h0000, 16'h0000, 8'h00, 12'h000, 8'h00, 5'd31}, 1'b1, 12'h200, ST_OK},
        '{'{2'd3, 16'hFFFF, 16'hFFFF, 8'hFF, 12'hFFF, 8'hFF, 5'd31}, 1'b1, 12'h200, ST_OK},
        '{'{MODE_EXEC, 16'h0000, 16'h0000, 8'h00, 12'h000, 8'h00, 5'd0}, 1'b1, 12'h202, ST_UNKNOWN},
        '{'{MODE_EXEC, OP_RET, 16'h0000, 8'h00, 12'h000, 8'h00, 5'd0}, 1'b1, 12'h204, ST_UNDER},
        '{'{MODE_EXEC, 16'hFFFF, 16'hFFFF, 8'hFF, 12'h000, 8'h00, 5'd0}, 1'b1, 12'h206, ST_UNKNOWN},
        '{'{MODE_EXEC, 16'h801F, 16'h0000, 8'h00, 12'h000, 8'h00, 5'd0}, 1'b1, 12'h208, ST_UNKNOWN},
        '{'{MODE_EXEC, 16'h5011, 16'h0000, 8'h00, 12'h000, 8'h00, 5'd0}, 1'b1, 12'h20A, ST_UNKNOWN},
        '{'{MODE_LOAD, 16'h0000, 16'h0000, 8'h00, 12'hFFF, 8'hFF, 5'd0}, 1'b0, 12'h000, ST_OK},
        '{'{MODE_LOAD, 16'h0000, 16'h0000, 8'h00, 12'h000, 8'h81, 5'd0}, 1'b0, 12'h000, ST_OK},
        '{'{MODE_EXEC, 16'hAFFF, 16'h0000, 8'h00, 12'h000, 8'h00, 5'd0}, 1'b0, 12'h000, ST_OK},
        '{'{MODE_EXEC, 16'h60FF, 16'h0000, 8'h00, 12'h000, 8'h00, 5'd0}, 1'b0, 12'h000, ST_OK},
        '{'{MODE_EXEC, 16'h611E, 16'h0000, 8'h00, 12'h000, 8'h00, 5'd0}, 1'b0, 12'h000, ST_OK},
        '{'{MODE_EXEC, 16'hD012, 16'h0000, 8'h00, 12'h000, 8'h00, 5'd0}, 1'b0, 12'h000, ST_OK},
        '{'{MODE_EXEC, 16'hD012, 16'h0000, 8'h00, 12'h000, 8'h00, 5'd0}, 1'b0, 12'h000, ST_OK},
        '{'{MODE_EXEC, 16'h6E00, 16'h0000, 8'h00, 12'h000, 8'h00, 5'd0}, 1'b0, 12'h000, ST_OK},
        '{'{MODE_EXEC, 16'hD0E2, 16'h0000, 8'h00, 12'h000, 8'h00, 5'd0}, 1'b0, 12'h000, ST_OK},
        '{'{MODE_READ, 16'h0000, 16'h0000, 8'h00, 12'h000, 8'h00, 5'd31}, 1'b0, 12'h000, ST_OK},
        '{'{MODE_EXEC, OP_CLS, 16'h0000, 8'h00, 12'h000, 8'h00, 5'd0}, 1'b0, 12'h000, ST_OK},
        '{'{MODE_EXEC, 16'h6FFF, 16'h0000, 8'h00, 12'h000, 8'h00, 5'd0}, 1'b0, 12'h000, ST_OK},
        '{'{MODE_EXEC, 16'h8F04, 16'h0000, 8'h00, 12'h000, 8'h00, 5'd0}, 1'b0, 12'h000, ST_OK},
        '{'{MODE_EXEC, 16'h8017, 16'h0000, 8'h00, 12'h000, 8'h00, 5'd0}, 1'b0, 12'h000, ST_OK},
        '{'{MODE_EXEC, 16'h801E, 16'h0000, 8'h00, 12'h000, 8'h00, 5'd0}, 1'b0, 12'h000, ST_OK},
        '{'{MODE_EXEC, 16'hC0AA, 16'h0000, 8'hFF, 12'h000, 8'h00, 5'd0}, 1'b0, 12'h000, ST_OK},
        '{'{MODE_EXEC, 16'hE09E, 16'hFFFF, 8'h00, 12'h000, 8'h00, 5'd0}, 1'b0, 12'h000, ST_OK},
        '{'{MODE_EXEC, 16'hF00A, 16'h0000, 8'h00, 12'h000, 8'h00, 5'd0}, 1'b0, 12'h000, ST_OK},
        '{'{MODE_EXEC, 16'hF00A, 16'h8000, 8'h00, 12'h000, 8'h00, 5'd0}, 1'b0, 12'h000, ST_OK},
        '{'{MODE_EXEC, 16'hBFFF, 16'h0000, 8'h00, 12'h000, 8'h00, 5'd0}, 1'b0, 12'h000, ST_OK},
        '{'{MODE_EXEC, 16'h2FFE, 16'h0000, 8'h00, 12'h000, 8'h00, 5'd0}, 1'b0, 12'h000, ST_OK}
    };

    // Stimulus.
    initial begin
        t_item it;
        foreach (v_reg[k]) v_reg[k] = '0;
        foreach (screen_q[k]) screen_q[k] = '0;
        foreach (mem_written[k]) mem_written[k] = 1'b0;
        foreach (mem_q[k]) mem_q[k] = '0;
        pc_q = PC_RESET;
        idx_q = '0;
        sp_q = 0;
        delay_q = '0;
        sound_q = '0;
        i_rst_n <= 1'b0;
        in_bus.valid <= 1'b0;
        in_bus.mode <= MODE_EXEC;
        in_bus.opcode <= '0;
        in_bus.keys <= '0;
        in_bus.random_byte <= '0;
        in_bus.load_address <= '0;
        in_bus.load_data <= '0;
        in_bus.row_select <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            send_item(trim_draw(directed[k].it), directed[k].known, directed[k].pc,
                      directed[k].status);
        end

        // Random part in four idling phases.
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            case (k * 4 / RANDOM_ITEMS)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 53; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 53; end
                default: begin tx_idle_pct = 18; rx_stall_pct = 18; end
            endcase
            // Once, hold back until every outstanding result has arrived.
            if (k == RANDOM_ITEMS / 2) begin
                in_bus.valid <= 1'b0;
                do @(posedge i_clk); while (expected_q.size() != 0);
            end
            it = trim_draw(random_item());
            send_item(it, 1'b0, 12'h000, ST_OK);
        end
        in_bus.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
